[design/sfc_pkg.sv]
`default_nettype none
package sfc_pkg;

    localparam int DEF_MAX_HALF_WIDTH = 3;
    localparam int DEF_SAMPLE_BITS    = 24;
    localparam int DEF_WEIGHT_BITS    = 16;

    localparam int DATA_BITS  = 32;
    localparam int VALUE_BITS = 42;
    localparam int HW_BITS    = 2;

    // register map, word index
    localparam int REG_HALF_WIDTH = 0;
    localparam int REG_TAP0       = 1;

    typedef struct packed {
        logic               valid;
        logic               emit;
        logic               nonzero;
        logic               last;
        logic               err;
        logic [HW_BITS-1:0] trail;
    } t_meta;

endpackage
`default_nettype wire

[design/sfc_in_if.sv]
`default_nettype none
interface sfc_in_if
    import sfc_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_last;

    modport source (output valid, output sample, output sample_last, input ready);
    modport sink   (input valid, input sample, input sample_last, output ready);
endinterface
`default_nettype wire

[design/sfc_out_if.sv]
`default_nettype none
interface sfc_out_if
    import sfc_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic                         result_last;
    logic                         too_short;

    modport source (output valid, output value, output result_last, output too_short,
                    input ready);
    modport sink   (input valid, input value, input result_last, input too_short,
                    output ready);
endinterface
`default_nettype wire

[design/sfc_cfg.sv]
`default_nettype none
module sfc_cfg
    import sfc_pkg::*;
#(
    parameter int MAX_HALF_WIDTH = DEF_MAX_HALF_WIDTH,
    parameter int WEIGHT_BITS    = DEF_WEIGHT_BITS,
    parameter int TAPS           = 2 * DEF_MAX_HALF_WIDTH + 1,
    parameter int ADDR_BITS      = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [ADDR_BITS-1:0]          i_paddr,
    input  wire logic [DATA_BITS-1:0]          i_pwdata,
    output logic      [DATA_BITS-1:0]          o_prdata,
    output logic                               o_pready,
    output logic      [HW_BITS-1:0]            o_half,
    output logic signed [WEIGHT_BITS-1:0]      o_weight [0:TAPS-1]
);
    localparam int IDX_BITS = ADDR_BITS - 2;

    logic        [HW_BITS-1:0]     r_half;
    logic signed [WEIGHT_BITS-1:0] r_weight [0:TAPS-1];
    logic        [IDX_BITS-1:0]    w_idx;
    logic                          w_wr;
    logic        [HW_BITS-1:0]     n_half;

    assign w_idx    = i_paddr[ADDR_BITS-1:2];
    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    // half width saturates at the largest kernel built
    assign n_half = (i_pwdata[HW_BITS-1:0] > HW_BITS'(MAX_HALF_WIDTH)) ?
                    HW_BITS'(MAX_HALF_WIDTH) : i_pwdata[HW_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= '0;
            for (int k = 0; k < TAPS; k++) r_weight[k] <= '0;
        end else if (w_wr) begin
            if (int'(w_idx) == REG_HALF_WIDTH) r_half <= n_half;
            for (int k = 0; k < TAPS; k++) begin
                if (int'(w_idx) == REG_TAP0 + k) r_weight[k] <= i_pwdata[WEIGHT_BITS-1:0];
            end
        end
    end

    always_comb begin
        o_prdata = '0;
        if (int'(w_idx) == REG_HALF_WIDTH) o_prdata = DATA_BITS'(r_half);
        for (int k = 0; k < TAPS; k++) begin
            if (int'(w_idx) == REG_TAP0 + k) o_prdata = DATA_BITS'(r_weight[k]);
        end
    end

    assign o_half   = r_half;
    assign o_weight = r_weight;

endmodule
`default_nettype wire

[design/sfc_cell.sv]
`default_nettype none
module sfc_cell
    import sfc_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
    localparam int PROD_BITS  = SAMPLE_BITS + WEIGHT_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_shift,
    input  wire logic                          i_head,
    input  wire logic signed [SAMPLE_BITS-1:0] i_new,
    input  wire logic signed [SAMPLE_BITS-1:0] i_prev,
    input  wire logic signed [WEIGHT_BITS-1:0] i_weight,
    input  wire logic                          i_use,
    output logic signed [SAMPLE_BITS-1:0]      o_sample,
    output logic signed [PROD_BITS-1:0]        o_prod
);
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [PROD_BITS-1:0]   w_mul;

    // the head cell takes the new sample, the others take their neighbor's
    always_ff @(posedge i_clk) begin
        if (i_shift) r_sample <= i_head ? i_new : i_prev;
    end

    assign w_mul    = r_sample * i_weight;
    assign o_prod   = i_use ? w_mul : '0;
    assign o_sample = r_sample;

endmodule
`default_nettype wire

[design/sfc_adder_tree.sv]
`default_nettype none
module sfc_adder_tree
    import sfc_pkg::*;
#(
    parameter int TAPS      = 2 * DEF_MAX_HALF_WIDTH + 1,
    parameter int PROD_BITS = DEF_SAMPLE_BITS + DEF_WEIGHT_BITS,
    parameter int ACC_BITS  = PROD_BITS + 3
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_adv,
    input  wire logic signed [PROD_BITS-1:0] i_prod [0:TAPS-1],
    output logic signed [ACC_BITS-1:0]       o_sum
);
    localparam int DEPTH = $clog2(TAPS);

    logic signed [ACC_BITS-1:0] r_lvl [0:DEPTH][0:TAPS-1];

    function automatic int level_count(input int l);
        return (TAPS + (1 << l) - 1) >> l;
    endfunction

    // level 0 registers the products, each later level adds pairs
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < TAPS; i++) r_lvl[0][i] <= ACC_BITS'(i_prod[i]);
            for (int l = 1; l <= DEPTH; l++) begin
                for (int i = 0; i < TAPS; i++) begin
                    if (2 * i + 1 < level_count(l - 1))
                        r_lvl[l][i] <= r_lvl[l-1][2*i] + r_lvl[l-1][2*i+1];
                    else if (2 * i < level_count(l - 1))
                        r_lvl[l][i] <= r_lvl[l-1][2*i];
                    else
                        r_lvl[l][i] <= '0;
                end
            end
        end
    end

    assign o_sum = r_lvl[DEPTH][0];

endmodule
`default_nettype wire

[design/sfc_out_stage.sv]
`default_nettype none
module sfc_out_stage
    import sfc_pkg::*;
#(
    parameter int ACC_BITS = DEF_SAMPLE_BITS + DEF_WEIGHT_BITS + 3
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_meta                      i_meta,
    input  wire logic signed [ACC_BITS-1:0] i_sum,
    output logic                            o_take,
    sfc_out_if.source                       o_res
);
    logic                         r_valid, n_valid;
    logic signed [VALUE_BITS-1:0] r_value, n_value;
    logic                         r_last, n_last;
    logic                         r_err, n_err;
    logic        [HW_BITS-1:0]    r_zeros, n_zeros;

    // trailing zeros hold the pipe until the last of them leaves
    assign o_take = !r_valid || (o_res.ready && r_zeros == '0);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_last  = r_last;
        n_err   = r_err;
        n_zeros = r_zeros;
        if (r_valid && o_res.ready && r_zeros != '0) begin
            n_value = '0;
            n_last  = (r_zeros == HW_BITS'(1));
            n_err   = 1'b0;
            n_zeros = r_zeros - 1'b1;
        end else if (o_take) begin
            if (i_meta.valid && i_meta.emit) begin
                n_valid = 1'b1;
                n_value = VALUE_BITS'(i_sum);
                n_last  = i_meta.last;
                n_err   = i_meta.err;
                n_zeros = i_meta.trail;
            end else begin
                n_valid = 1'b0;
                n_zeros = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_zeros <= '0;
        end else begin
            r_valid <= n_valid;
            r_zeros <= n_zeros;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_last  <= n_last;
        r_err   <= n_err;
    end

    assign o_res.valid       = r_valid;
    assign o_res.value       = r_value;
    assign o_res.result_last = r_last;
    assign o_res.too_short   = r_err;

    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_err |-> r_last && r_zeros == '0 && r_value == '0)
        else $error("error beat carries data or trailing zeros");

    a_zero_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && o_res.ready && r_zeros != '0 |=> r_valid && r_value == '0 && !r_err)
        else $error("trailing zero beat malformed");

endmodule
`default_nettype wire

[design/same_size_fir_convolution_core.sv]
// same-length fir filter, centred correlation with a 2h+1 tap kernel and zero borders
// i_smp: sample beats (valid/ready), sample_last marks the end of a stream
// o_res: result beats (valid/ready), one per sample, the first and last h are zero;
//   result_last marks the end, too_short flags a stream shorter than the kernel,
//   which ends in that single beat (zeros already sent for it are to be dropped)
// apb port: word 0 half width, words 1.. tap weights, tap0 weights the oldest sample
// pipeline: an accepted sample passes through the window cells, the product register,
//   the adder tree levels and the output register
// throughput: one sample per cycle while the receiver takes results; the last sample of a
//   stream with h > 0 keeps ready low while its trailing zeros leave the output register
// reset: stream position, pipeline valids, config registers cleared; no clearing pass
// receiver stall: the output register holds, the whole pipe freezes and ready drops
`default_nettype none
module same_size_fir_convolution_core
    import sfc_pkg::*;
#(
    parameter int MAX_HALF_WIDTH = DEF_MAX_HALF_WIDTH,
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int WEIGHT_BITS    = DEF_WEIGHT_BITS,
    localparam int TAPS          = 2 * MAX_HALF_WIDTH + 1,
    localparam int ADDR_BITS     = $clog2(TAPS + 1) + 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    sfc_in_if.sink                    i_smp,
    sfc_out_if.source                 o_res,
    input  wire logic                 i_psel,
    input  wire logic                 i_penable,
    input  wire logic                 i_pwrite,
    input  wire logic [ADDR_BITS-1:0] i_paddr,
    input  wire logic [DATA_BITS-1:0] i_pwdata,
    output logic      [DATA_BITS-1:0] o_prdata,
    output logic                      o_pready
);
    localparam int PROD_BITS = SAMPLE_BITS + WEIGHT_BITS;
    localparam int ACC_BITS  = PROD_BITS + $clog2(TAPS);
    localparam int DEPTH     = $clog2(TAPS);
    localparam int SEEN_BITS = $clog2(TAPS + 1);

    logic        [HW_BITS-1:0]     w_half;
    logic signed [WEIGHT_BITS-1:0] w_weight [0:TAPS-1];
    logic signed [SAMPLE_BITS-1:0] w_win    [0:TAPS-1];
    logic signed [SAMPLE_BITS-1:0] w_prev   [0:TAPS-1];
    logic signed [PROD_BITS-1:0]   w_prod   [0:TAPS-1];
    logic                          w_head   [0:TAPS-1];
    logic                          w_use    [0:TAPS-1];
    logic signed [ACC_BITS-1:0]    w_sum;
    logic                          w_adv;
    logic                          w_fire;

    logic [SEEN_BITS-1:0] r_seen, n_seen;
    t_meta                r_meta [0:DEPTH+1];
    t_meta                n_meta0;

    sfc_cfg #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .WEIGHT_BITS    (WEIGHT_BITS),
        .TAPS           (TAPS),
        .ADDR_BITS      (ADDR_BITS)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_half    (w_half),
        .o_weight  (w_weight)
    );

    assign i_smp.ready = w_adv;
    assign w_fire      = i_smp.valid && w_adv;

    // stream position and per-beat result plan
    always_comb begin
        int j;
        int h;
        logic is_last;
        j       = int'(r_seen);
        h       = int'(w_half);
        is_last = i_smp.sample_last;
        n_meta0         = '0;
        n_meta0.valid   = w_fire;
        n_meta0.err     = is_last && (j < 2 * h);
        n_meta0.emit    = n_meta0.err || (j >= h);
        n_meta0.nonzero = !n_meta0.err && (j >= 2 * h);
        n_meta0.last    = n_meta0.err || (is_last && h == 0);
        n_meta0.trail   = (is_last && !n_meta0.err) ? w_half : '0;
        n_seen = r_seen;
        if (w_fire) begin
            if (is_last) n_seen = '0;
            else if (r_seen != SEEN_BITS'(TAPS)) n_seen = r_seen + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            for (int k = 0; k <= DEPTH + 1; k++) r_meta[k] <= '0;
        end else begin
            r_seen <= n_seen;
            if (w_adv) begin
                r_meta[0] <= n_meta0;
                for (int k = 1; k <= DEPTH + 1; k++) r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // the window enters at cell 2*(max - h), so cell k always uses weight taps-1-k
    always_comb begin
        int e;
        e = 2 * (MAX_HALF_WIDTH - int'(w_half));
        w_prev[0] = i_smp.sample;
        for (int k = 1; k < TAPS; k++) w_prev[k] = w_win[k-1];
        for (int k = 0; k < TAPS; k++) begin
            w_head[k] = (k == e);
            w_use[k]  = (k >= e) && r_meta[0].nonzero;
        end
    end

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        sfc_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .WEIGHT_BITS (WEIGHT_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_shift  (w_fire),
            .i_head   (w_head[k]),
            .i_new    (i_smp.sample),
            .i_prev   (w_prev[k]),
            .i_weight (w_weight[TAPS-1-k]),
            .i_use    (w_use[k]),
            .o_sample (w_win[k]),
            .o_prod   (w_prod[k])
        );
    end

    sfc_adder_tree #(
        .TAPS      (TAPS),
        .PROD_BITS (PROD_BITS),
        .ACC_BITS  (ACC_BITS)
    ) u_tree (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_prod (w_prod),
        .o_sum  (w_sum)
    );

    sfc_out_stage #(
        .ACC_BITS (ACC_BITS)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_meta  (r_meta[DEPTH+1]),
        .i_sum   (w_sum),
        .o_take  (w_adv),
        .o_res   (o_res)
    );

    a_seen_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && i_smp.sample_last |=> r_seen == '0)
        else $error("stream position not restarted after last beat");

    a_err_plan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_meta[0].valid && r_meta[0].err |->
            !r_meta[0].nonzero && r_meta[0].trail == '0 && r_meta[0].last && r_meta[0].emit)
        else $error("short stream beat planned with data or trailing zeros");

endmodule
`default_nettype wire

[verif/tb_same_size_fir_convolution_core.sv]
`default_nettype none
module tb_same_size_fir_convolution_core;
    import sfc_pkg::*;

    localparam int TAP_COUNT   = 2 * DEF_MAX_HALF_WIDTH + 1;
    localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
    localparam int WEIGHT_BITS = DEF_WEIGHT_BITS;
    localparam int ADDR_BITS   = $clog2(TAP_COUNT + 1) + 2;
    localparam int DRAIN_SLACK = 12;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_ITEMS = 35;
    localparam int PHASE_COUNT = 8;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sample_last;
    } t_sample_beat;

    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        logic                         result_last;
        logic                         too_short;
    } t_result_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    sfc_in_if  smp_if ();
    sfc_out_if res_if ();

    same_size_fir_convolution_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_smp     (smp_if),
        .o_res     (res_if),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // filter model state, mirrors what has been written over apb
    logic [HW_BITS-1:0]            cfg_half;
    logic signed [WEIGHT_BITS-1:0] cfg_tap [TAP_COUNT];
    logic signed [SAMPLE_BITS-1:0] history [TAP_COUNT];   // newest first
    int unsigned                   stream_pos;             // saturates at seven

    t_sample_beat pending_samples[$];
    t_result_beat expected_outputs[$];

    int  error_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic rx_hold = 1'b0;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic push_result(input logic signed [VALUE_BITS-1:0] v, input logic lst,
                               input logic err);
        t_result_beat r;
        r.value       = v;
        r.result_last = lst;
        r.too_short   = err;
        expected_outputs.push_back(r);
    endtask

    // expected output beats caused by one accepted sample
    task automatic compute_filter_outputs(input t_sample_beat b);
        int unsigned h;
        int unsigned ntaps;
        int unsigned pos;
        int unsigned i;
        int unsigned k;
        longint      acc;
        h     = cfg_half;
        ntaps = 2 * h + 1;
        pos   = stream_pos;
        for (i = TAP_COUNT - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0] = b.sample;

        if (b.sample_last && pos + 1 < ntaps) begin
            push_result('0, 1'b1, 1'b1);
            stream_pos = 0;
            return;
        end

        if (pos >= h) begin
            acc = 0;
            if (pos >= 2 * h) begin
                for (k = 0; k < ntaps; k++)
                    acc += longint'(history[2*h-k]) * longint'(cfg_tap[k]);
            end
            push_result(acc[VALUE_BITS-1:0], b.sample_last && h == 0, 1'b0);
        end

        if (b.sample_last) begin
            for (k = 0; k < h; k++)
                push_result('0, k + 1 == h, 1'b0);
            stream_pos = 0;
        end else if (stream_pos < TAP_COUNT) begin
            stream_pos++;
        end
    endtask

    always @(posedge i_clk) begin : sample_driver
        t_sample_beat head;
        if (!i_rst_n) begin
            smp_if.valid <= 1'b0;
        end else begin
            if (smp_if.valid && smp_if.ready)
                compute_filter_outputs(pending_samples.pop_front());
            if (!smp_if.valid || smp_if.ready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    head = pending_samples[0];
                    smp_if.valid       <= 1'b1;
                    smp_if.sample      <= head.sample;
                    smp_if.sample_last <= head.sample_last;
                end else begin
                    smp_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result_beat want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_outputs.size() == 0) begin
                    report_mismatch($sformatf("result beat value %0d with nothing expected",
                                              res_if.value));
                end else begin
                    want = expected_outputs.pop_front();
                    if (res_if.value !== want.value)
                        report_mismatch($sformatf("value got %0d want %0d",
                                                  res_if.value, want.value));
                    if (res_if.result_last !== want.result_last)
                        report_mismatch($sformatf("result_last got %b want %b",
                                                  res_if.result_last, want.result_last));
                    if (res_if.too_short !== want.too_short)
                        report_mismatch($sformatf("too_short got %b want %b",
                                                  res_if.too_short, want.too_short));
                end
            end
            res_if.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic reg_write(input int idx, input logic [DATA_BITS-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // upper bits of each word carry junk, the block keeps only the field
    task automatic apply_config(input logic [HW_BITS-1:0] h,
                                input logic signed [WEIGHT_BITS-1:0] w [TAP_COUNT]);
        logic [DATA_BITS-1:0] junk;
        int i;
        junk = $urandom();
        reg_write(REG_HALF_WIDTH, {junk[DATA_BITS-1:HW_BITS], h});
        cfg_half = h;
        for (i = 0; i < TAP_COUNT; i++) begin
            junk = $urandom();
            reg_write(REG_TAP0 + i, {junk[DATA_BITS-1:WEIGHT_BITS], w[i]});
            cfg_tap[i] = w[i];
        end
    endtask

    task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic lst);
        t_sample_beat b;
        b.sample      = s;
        b.sample_last = lst;
        pending_samples.push_back(b);
    endtask

    task automatic queue_stream(input int len);
        logic [31:0] raw;
        int n;
        for (n = 0; n < len; n++) begin
            raw = $urandom();
            case ($urandom_range(7))
                0:       queue_sample(SAMPLE_MAX, n == len - 1);
                1:       queue_sample(SAMPLE_MIN, n == len - 1);
                default: queue_sample(raw[SAMPLE_BITS-1:0], n == len - 1);
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || expected_outputs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    initial begin : run_limit
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        logic signed [WEIGHT_BITS-1:0] weights [TAP_COUNT];
        logic [31:0]        raw;
        logic [HW_BITS-1:0] h;
        int phase;
        int queued;
        int len;
        int i;

        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        smp_if.valid       = 1'b0;
        smp_if.sample      = '0;
        smp_if.sample_last = 1'b0;
        res_if.ready       = 1'b0;
        cfg_half           = '0;
        stream_pos         = 0;
        for (i = 0; i < TAP_COUNT; i++) begin
            cfg_tap[i] = '0;
            history[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // widest kernel, all weights at the negative extreme
        for (i = 0; i < TAP_COUNT; i++)
            weights[i] = WEIGHT_MIN;
        apply_config(2'd3, weights);
        for (i = 0; i < TAP_COUNT; i++)
            queue_sample(SAMPLE_MIN, i == TAP_COUNT - 1);
        queue_sample(SAMPLE_MAX, 1'b1);          // single sample, too short
        queue_sample(SAMPLE_MAX, 1'b0);          // five samples, one zero then error
        queue_sample(SAMPLE_MIN, 1'b0);
        queue_sample('0, 1'b0);
        queue_sample(SAMPLE_BITS'(-1), 1'b0);
        queue_sample(SAMPLE_MAX, 1'b1);
        wait_drained();

        // zero half width: every sample gives its own product
        for (i = 0; i < TAP_COUNT; i++)
            weights[i] = '0;
        weights[0] = WEIGHT_MAX;
        apply_config(2'd0, weights);
        queue_sample(SAMPLE_MAX, 1'b1);
        queue_sample(SAMPLE_MIN, 1'b0);
        queue_sample(SAMPLE_BITS'(-1), 1'b1);
        wait_drained();

        // three taps, stream exactly as long as the kernel, then one too short
        weights[0] = WEIGHT_MIN;
        weights[1] = WEIGHT_MAX;
        weights[2] = WEIGHT_BITS'(1);
        apply_config(2'd1, weights);
        queue_sample(SAMPLE_MAX, 1'b0);
        queue_sample(SAMPLE_MIN, 1'b0);
        queue_sample(SAMPLE_MAX, 1'b1);
        queue_sample(SAMPLE_BITS'(1), 1'b0);
        queue_sample(SAMPLE_BITS'(2), 1'b1);
        wait_drained();

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            h = (phase < 4) ? HW_BITS'(3 - phase) : HW_BITS'($urandom_range(3));
            for (i = 0; i < TAP_COUNT; i++) begin
                raw = $urandom();
                case ($urandom_range(7))
                    0:       weights[i] = WEIGHT_MAX;
                    1:       weights[i] = WEIGHT_MIN;
                    2:       weights[i] = '0;
                    default: weights[i] = raw[WEIGHT_BITS-1:0];
                endcase
            end
            apply_config(h, weights);

            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase

            // receiver goes quiet while the sender keeps pushing, pipe backs up
            if (phase == 4) begin
                fork
                    begin
                        @(posedge i_clk);
                        rx_hold <= 1'b1;
                        repeat (LONG_HOLD) @(posedge i_clk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end

            queued = 0;
            while (queued < PHASE_ITEMS) begin
                if (h != 0 && $urandom_range(9) == 0)
                    len = $urandom_range(2 * h, 1);
                else
                    len = $urandom_range(2 * h + 10, 2 * h + 1);
                queue_stream(len);
                queued += len;
            end
            wait_drained();
        end

        repeat (DRAIN_SLACK) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire
